>>> design/fmacl_pkg.sv
// Shared types and constants for the first-match access control table.
// Used by fmacl_store and first_match_acl_table; no dependencies.
package fmacl_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int ID_BITS     = 8;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_DEFAULT = 2'd1,
		ACT_LOOKUP  = 2'd2
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic               pol;
	} rule_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		rule_t            wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

>>> design/first_match_acl_table.sv
// First-match access control table: sequencer, result register and rule store.
// Append, action code 3 and operations on an empty table answer in the cycle after start.
// Lookup and set-default scan the stored rules through the single read port,
// one per cycle, a lookup stopping at its first match; busy is high until the
// answer, so no new word is taken while a scan runs.
// One word per answer, shown for one cycle with done; the receiver cannot stall.
// Reset (arst_n low, asynchronous) empties the table and sets the default to deny.
module first_match_acl_table
	import fmacl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] command_id,
	input  logic       rule_policy,
	output logic       done,
	output logic       decision,
	output logic       status
);

	state_t             state_q, state_d;
	logic               lookup_q, lookup_d;
	logic [ID_BITS-1:0] id_q, id_d;
	logic               pol_q, pol_d;
	logic               dflt_q, dflt_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [CNT_W-1:0]   rd_q, rd_d;
	logic [CNT_W-1:0]   wr_q, wr_d;
	logic               rdv_s1, rdv_d;
	logic               done_q, done_d;
	logic               dec_q, dec_d;
	logic               stat_q, stat_d;

	mem_req_t req;
	rule_t    rdata;
	logic     need_scan, hit, last, finish, keep;

	fmacl_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign need_scan = ((action == ACT_DEFAULT) || (action == ACT_LOOKUP)) &&
		(cnt_q != '0);
	assign hit    = rdv_s1 && lookup_q && (rdata.id == id_q);
	assign last   = rdv_s1 && (rd_q == cnt_q);
	assign finish = hit || last;
	assign keep   = rdv_s1 && !lookup_q && (rdata.pol != pol_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && need_scan) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req      = '0;
		lookup_d = lookup_q;
		id_d     = id_q;
		pol_d    = pol_q;
		dflt_d   = dflt_q;
		cnt_d    = cnt_q;
		rd_d     = rd_q;
		wr_d     = wr_q;
		rdv_d    = 1'b0;
		done_d   = 1'b0;
		dec_d    = 1'b0;
		stat_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					lookup_d = (action == ACT_LOOKUP);
					id_d     = command_id[ID_BITS-1:0];
					pol_d    = rule_policy;
					rd_d     = '0;
					wr_d     = '0;
					case (action)
						ACT_APPEND: begin
							done_d = 1'b1;
							if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
								stat_d = 1'b1;
							end else begin
								req.we          = 1'b1;
								req.waddr       = cnt_q[IDX_W-1:0];
								req.wdata.id    = command_id[ID_BITS-1:0];
								req.wdata.pol   = rule_policy;
								cnt_d           = cnt_q + 1'b1;
							end
						end
						ACT_DEFAULT: begin
							dflt_d = rule_policy;
							if (cnt_q == '0) done_d = 1'b1;
						end
						ACT_LOOKUP: begin
							if (cnt_q == '0) begin
								done_d = 1'b1;
								dec_d  = dflt_q;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				req.re    = (rd_q != cnt_q);
				req.raddr = rd_q[IDX_W-1:0];
				rd_d      = rd_q + CNT_W'(req.re);
				rdv_d     = req.re && !finish;
				if (keep) begin
					req.we    = 1'b1;
					req.waddr = wr_q[IDX_W-1:0];
					req.wdata = rdata;
					wr_d      = wr_q + 1'b1;
				end
				if (hit) begin
					done_d = 1'b1;
					dec_d  = rdata.pol;
				end else if (last) begin
					done_d = 1'b1;
					dec_d  = lookup_q ? dflt_q : 1'b0;
					if (!lookup_q) cnt_d = wr_q + CNT_W'(keep);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dflt_q  <= 1'b0;
			cnt_q   <= '0;
			rdv_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			dflt_q  <= dflt_d;
			cnt_q   <= cnt_d;
			rdv_s1  <= rdv_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		lookup_q <= lookup_d;
		id_q     <= id_d;
		pol_q    <= pol_d;
		rd_q     <= rd_d;
		wr_q     <= wr_d;
		dec_q    <= dec_d;
		stat_q   <= stat_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign decision = dec_q;
	assign status   = stat_q;

endmodule

>>> design/fmacl_store.sv
// Rule storage: one write port and one registered read port.
// Depends on fmacl_pkg.
module fmacl_store
	import fmacl_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output rule_t    rdata
);

	rule_t mem [TABLE_DEPTH];
	rule_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> bench/first_match_acl_table_tb.sv
// Testbench for first_match_acl_table: directed and random append, set-default
// and lookup words, answers checked against a behavioral rule table.
// Depends on fmacl_pkg and the first_match_acl_table RTL.
module first_match_acl_table_tb;
	import fmacl_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 580;

	typedef struct packed {
		logic decision;
		logic status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] action = 2'd0;
	logic [7:0] command_id = 8'd0;
	logic rule_policy = 1'b0;
	logic busy;
	logic done;
	logic decision;
	logic status;

	logic [ID_BITS-1:0] rule_ids [TABLE_DEPTH];
	logic rule_pols [TABLE_DEPTH];
	int rule_total = 0;
	logic default_pol = 1'b0;
	answer_t expected_answers [$];
	int errors = 0;
	int cycles = 0;
	bit no_gaps = 1'b0;

	first_match_acl_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.command_id(command_id),
		.rule_policy(rule_policy),
		.done(done),
		.decision(decision),
		.status(status)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic answer_t acl_answer(logic [1:0] act, logic [7:0] cid, logic pol);
		answer_t ans;
		int kept;
		ans = '0;
		kept = 0;
		case (act)
			ACT_APPEND: begin
				if (rule_total == TABLE_DEPTH) begin
					ans.status = 1'b1;
				end else begin
					rule_ids[rule_total] = cid[ID_BITS-1:0];
					rule_pols[rule_total] = pol;
					rule_total++;
				end
			end
			ACT_DEFAULT: begin
				default_pol = pol;
				for (int i = 0; i < rule_total; i++) begin
					if (rule_pols[i] != pol) begin
						rule_ids[kept] = rule_ids[i];
						rule_pols[kept] = rule_pols[i];
						kept++;
					end
				end
				rule_total = kept;
			end
			ACT_LOOKUP: begin
				ans.decision = default_pol;
				for (int i = rule_total - 1; i >= 0; i--)
					if (rule_ids[i] == cid[ID_BITS-1:0])
						ans.decision = rule_pols[i];
			end
			default: ;
		endcase
		return ans;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected answer: expected none, actual decision=%0b status=%0b",
					$time, decision, status);
				errors++;
			end else begin
				want = expected_answers.pop_front();
				if (decision !== want.decision) begin
					$display("%0t: decision mismatch: expected %0b, actual %0b",
						$time, want.decision, decision);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0b, actual %0b",
						$time, want.status, status);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy)
			expected_answers.push_back(acl_answer(action, command_id, rule_policy));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] act, logic [7:0] cid, logic pol);
		int gap;
		int r;
		r = $urandom_range(99, 0);
		if (no_gaps || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(3, 1);
		else
			gap = $urandom_range(40, 8);
		if (gap > 0) begin
			start <= 1'b0;
			action <= 2'($urandom);
			command_id <= 8'($urandom);
			rule_policy <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		command_id <= cid;
		rule_policy <= pol;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_for_answers();
		start <= 1'b0;
		do @(posedge clk); while (expected_answers.size() != 0);
	endtask

	task automatic test_empty_table();
		send_word(ACT_LOOKUP, 8'h00, 1'b1);
		send_word(ACT_LOOKUP, 8'hFF, 1'b0);
		send_word(ACT_DEFAULT, 8'h00, 1'b1);
		send_word(ACT_LOOKUP, 8'h5A, 1'b0);
		send_word(ACT_DEFAULT, 8'hFF, 1'b0);
	endtask

	task automatic test_append_lookup();
		send_word(ACT_APPEND, 8'h00, 1'b1);
		send_word(ACT_APPEND, 8'hFF, 1'b0);
		send_word(ACT_APPEND, 8'h00, 1'b0);
		send_word(ACT_APPEND, 8'hA5, 1'b1);
		send_word(ACT_LOOKUP, 8'h00, 1'b0);
		send_word(ACT_LOOKUP, 8'hFF, 1'b1);
		send_word(ACT_LOOKUP, 8'hA5, 1'b0);
		send_word(ACT_LOOKUP, 8'h33, 1'b1);
	endtask

	task automatic test_compaction();
		send_word(ACT_DEFAULT, 8'h12, 1'b1);
		send_word(ACT_LOOKUP, 8'h00, 1'b1);
		send_word(ACT_LOOKUP, 8'hA5, 1'b0);
		send_word(ACT_DEFAULT, 8'h34, 1'b0);
		send_word(ACT_LOOKUP, 8'hFF, 1'b1);
	endtask

	task automatic test_unused_action();
		send_word(ACT_UNUSED, 8'hFF, 1'b1);
		send_word(ACT_UNUSED, 8'h00, 1'b0);
		send_word(ACT_LOOKUP, 8'hFF, 1'b0);
	endtask

	task automatic test_table_full();
		wait_for_answers();
		no_gaps = 1'b1;
		repeat (TABLE_DEPTH) send_word(ACT_APPEND, 8'($urandom), 1'($urandom));
		no_gaps = 1'b0;
		send_word(ACT_APPEND, 8'hC3, 1'b1);
		send_word(ACT_APPEND, 8'h3C, 1'b0);
		send_word(ACT_LOOKUP, 8'hC3, 1'b0);
		send_word(ACT_LOOKUP, 8'($urandom), 1'b0);
		send_word(ACT_DEFAULT, 8'($urandom), 1'($urandom));
	endtask

	task automatic test_random();
		int sent;
		int len;
		int append_pct;
		int r;
		bit narrow;
		logic [7:0] cid;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			no_gaps = ($urandom_range(3, 0) == 0);
			narrow = $urandom_range(1, 0);
			append_pct = $urandom_range(1, 0) ? 80 : 45;
			len = $urandom_range(50, 10);
			repeat (len) begin
				r = $urandom_range(99, 0);
				cid = narrow ? 8'($urandom_range(7, 0)) : 8'($urandom);
				// bias non-append words toward identifiers already in the table
				if (r >= append_pct && rule_total > 0 && $urandom_range(1, 0))
					cid = rule_ids[$urandom_range(rule_total - 1, 0)];
				if (r < append_pct)
					send_word(ACT_APPEND, cid, 1'($urandom));
				else if (r < 92)
					send_word(ACT_LOOKUP, cid, 1'($urandom));
				else if (r < 96)
					send_word(ACT_UNUSED, cid, 1'($urandom));
				else
					send_word(ACT_DEFAULT, cid, 1'($urandom));
			end
			send_word(ACT_DEFAULT, 8'($urandom), 1'($urandom));
			sent += len + 1;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_append_lookup();
		test_compaction();
		test_unused_action();
		test_table_full();
		test_random();
		wait_for_answers();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
